@@ hw/rtl/euzr_pkg.sv @@
// ----------------------------------------------------------------------------
// euzr_pkg
// Shared types, constants and helpers for the Euler ZYX rotation matrix block.
// ----------------------------------------------------------------------------
`default_nettype none

package euzr_pkg;

    // field widths
    localparam int ANGLE_W = 16;
    localparam int ENTRY_W = 16;
    localparam int SC_W    = 32;   // sine and cosine, signed Q2.29
    localparam int U_W     = 30;   // folded angle magnitude, Q29
    localparam int U2_W    = 31;   // squared magnitude, Q29
    localparam int TERM_W  = 31;   // series term, Q29
    localparam int DIV_W   = 9;

    // series length and pipeline depths
    localparam int SERIES_TERMS = 8;
    localparam int SC_LAT       = 3 * SERIES_TERMS + 4;
    localparam int MAT_LAT      = 4;
    localparam int PIPE_LAT     = SC_LAT + MAT_LAT;

    // angle constants in Q2.29
    localparam logic signed [32:0] PI_Q29      = 33'sd1686629713;
    localparam logic signed [32:0] HALF_PI_Q29 = 33'sd843314857;
    localparam logic [TERM_W-1:0]  Q29_ONE     = TERM_W'(32'd536870912);
    localparam logic signed [15:0] ENTRY_MAX   = 16'sd16384;

    typedef logic [DIV_W-1:0] div_t;

    // per-term divisors n*(n+1) for sine and (n-1)*n for cosine
    localparam div_t SIN_DIV [SERIES_TERMS] = '{
        9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272
    };
    localparam div_t COS_DIV [SERIES_TERMS] = '{
        9'd2, 9'd12, 9'd30, 9'd56, 9'd90, 9'd132, 9'd182, 9'd240
    };

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic signed [ANGLE_W-1:0] pitch_angle;
        logic signed [ANGLE_W-1:0] yaw_angle;
    } in_t;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] m00;
        logic signed [ENTRY_W-1:0] m01;
        logic signed [ENTRY_W-1:0] m02;
        logic signed [ENTRY_W-1:0] m10;
        logic signed [ENTRY_W-1:0] m11;
        logic signed [ENTRY_W-1:0] m12;
        logic signed [ENTRY_W-1:0] m20;
        logic signed [ENTRY_W-1:0] m21;
        logic signed [ENTRY_W-1:0] m22;
    } out_t;

    typedef struct packed {
        logic signed [SC_W-1:0] sine;
        logic signed [SC_W-1:0] cosine;
    } sc_t;

    // round half up from Q58 to Q14 and clamp to plus or minus one
    function automatic logic signed [ENTRY_W-1:0] finish_entry(
        input logic signed [63:0] q58
    );
        logic signed [63:0] v;
        logic signed [ENTRY_W-1:0] r;
        v = (q58 + 64'sd8796093022208) >>> 44;
        if (v > 64'(ENTRY_MAX)) begin
            r = ENTRY_MAX;
        end else if (v < -64'(ENTRY_MAX)) begin
            r = -ENTRY_MAX;
        end else begin
            r = v[ENTRY_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/euler_zyx_to_rotation_matrix.sv @@
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix
// Roll, pitch and yaw in Q2.13 to the nine Q1.14 entries of Rz*Ry*Rx.
// ----------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_data carries one angle triple per
// transaction; output channel m_valid/m_ready/m_data carries the nine
// matrix entries, rounded and clamped to plus or minus one.
// Each angle runs through its own sine/cosine pipeline (fold, square,
// rounding of the square, three stages per series term for eight terms,
// sign fix), then through the matrix stages (products, rounding,
// products, sum and clamp).
// Throughput is one transaction per cycle while the output is not stalled;
// the three angles run through their own sine/cosine pipelines side by side.
// The whole pipeline advances together: while a result waits at the output
// and m_ready is low, every stage holds and s_ready is low, so nothing is
// lost or repeated. A bubble at the output lets the pipeline move on.
// Reset (aresetn low at a clock edge) clears all valid bits; data registers
// are not reset. The block keeps no state between transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_zyx_to_rotation_matrix
    import euzr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic [PIPE_LAT-1:0] vld_reg;
    logic                adv;

    // whole pipeline steps when the output slot is free or being taken
    assign adv     = !vld_reg[PIPE_LAT-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[PIPE_LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    // sine and cosine of each angle
    sc_t roll_sc;
    sc_t pitch_sc;
    sc_t yaw_sc;

    euzr_sincos u_roll (
        .aclk   (aclk),
        .en     (adv),
        .angle  (s_data.roll_angle),
        .result (roll_sc)
    );

    euzr_sincos u_pitch (
        .aclk   (aclk),
        .en     (adv),
        .angle  (s_data.pitch_angle),
        .result (pitch_sc)
    );

    euzr_sincos u_yaw (
        .aclk   (aclk),
        .en     (adv),
        .angle  (s_data.yaw_angle),
        .result (yaw_sc)
    );

    // first products
    logic signed [63:0] p_cysp_reg, p_sysp_reg;
    logic signed [63:0] p_cycp_reg, p_sycp_reg, p_sycr_reg, p_sysr_reg;
    logic signed [63:0] p_cycr_reg, p_cysr_reg, p_cpsr_reg, p_cpcr_reg;
    logic signed [SC_W-1:0] sr1_reg, cr1_reg, sp1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            p_cysp_reg <= yaw_sc.cosine * pitch_sc.sine;
            p_sysp_reg <= yaw_sc.sine * pitch_sc.sine;
            p_cycp_reg <= yaw_sc.cosine * pitch_sc.cosine;
            p_sycp_reg <= yaw_sc.sine * pitch_sc.cosine;
            p_sycr_reg <= yaw_sc.sine * roll_sc.cosine;
            p_sysr_reg <= yaw_sc.sine * roll_sc.sine;
            p_cycr_reg <= yaw_sc.cosine * roll_sc.cosine;
            p_cysr_reg <= yaw_sc.cosine * roll_sc.sine;
            p_cpsr_reg <= pitch_sc.cosine * roll_sc.sine;
            p_cpcr_reg <= pitch_sc.cosine * roll_sc.cosine;
            sr1_reg    <= roll_sc.sine;
            cr1_reg    <= roll_sc.cosine;
            sp1_reg    <= pitch_sc.sine;
        end
    end

    // round cy*sp and sy*sp back to Q29
    logic signed [63:0] cysp_round;
    logic signed [63:0] sysp_round;
    logic signed [SC_W-1:0] cysp2_reg, sysp2_reg;
    logic signed [63:0] p_cycp2_reg, p_sycp2_reg, p_sycr2_reg, p_sysr2_reg;
    logic signed [63:0] p_cycr2_reg, p_cysr2_reg, p_cpsr2_reg, p_cpcr2_reg;
    logic signed [SC_W-1:0] sr2_reg, cr2_reg, sp2_reg;

    assign cysp_round = (p_cysp_reg + 64'sd268435456) >>> 29;
    assign sysp_round = (p_sysp_reg + 64'sd268435456) >>> 29;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cysp2_reg   <= cysp_round[SC_W-1:0];
            sysp2_reg   <= sysp_round[SC_W-1:0];
            p_cycp2_reg <= p_cycp_reg;
            p_sycp2_reg <= p_sycp_reg;
            p_sycr2_reg <= p_sycr_reg;
            p_sysr2_reg <= p_sysr_reg;
            p_cycr2_reg <= p_cycr_reg;
            p_cysr2_reg <= p_cysr_reg;
            p_cpsr2_reg <= p_cpsr_reg;
            p_cpcr2_reg <= p_cpcr_reg;
            sr2_reg     <= sr1_reg;
            cr2_reg     <= cr1_reg;
            sp2_reg     <= sp1_reg;
        end
    end

    // second products with the roll terms
    logic signed [63:0] q_cyspsr_reg, q_cyspcr_reg, q_syspsr_reg, q_syspcr_reg;
    logic signed [63:0] p_cycp3_reg, p_sycp3_reg, p_sycr3_reg, p_sysr3_reg;
    logic signed [63:0] p_cycr3_reg, p_cysr3_reg, p_cpsr3_reg, p_cpcr3_reg;
    logic signed [SC_W-1:0] sp3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_cyspsr_reg <= cysp2_reg * sr2_reg;
            q_cyspcr_reg <= cysp2_reg * cr2_reg;
            q_syspsr_reg <= sysp2_reg * sr2_reg;
            q_syspcr_reg <= sysp2_reg * cr2_reg;
            p_cycp3_reg  <= p_cycp2_reg;
            p_sycp3_reg  <= p_sycp2_reg;
            p_sycr3_reg  <= p_sycr2_reg;
            p_sysr3_reg  <= p_sysr2_reg;
            p_cycr3_reg  <= p_cycr2_reg;
            p_cysr3_reg  <= p_cysr2_reg;
            p_cpsr3_reg  <= p_cpsr2_reg;
            p_cpcr3_reg  <= p_cpcr2_reg;
            sp3_reg      <= sp2_reg;
        end
    end

    // sums, rounding to Q14 and clamping
    out_t out_next;
    out_t out_reg;

    always_comb begin
        out_next.m00 = finish_entry(p_cycp3_reg);
        out_next.m01 = finish_entry(q_cyspsr_reg - p_sycr3_reg);
        out_next.m02 = finish_entry(p_sysr3_reg + q_cyspcr_reg);
        out_next.m10 = finish_entry(p_sycp3_reg);
        out_next.m11 = finish_entry(p_cycr3_reg + q_syspsr_reg);
        out_next.m12 = finish_entry(q_syspcr_reg - p_cysr3_reg);
        out_next.m20 = finish_entry(-(64'(sp3_reg) <<< 29));
        out_next.m21 = finish_entry(p_cpsr3_reg);
        out_next.m22 = finish_entry(p_cpcr3_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // a waiting result stalls the whole pipeline
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

    // an accepted transaction enters the first valid stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transaction not tracked");

    // diagonal entry stays within plus or minus one
    a_m00_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.m00 <= ENTRY_MAX && m_data.m00 >= -ENTRY_MAX))
        else $error("m00 out of range");

    // corner entry stays within plus or minus one
    a_m22_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.m22 <= ENTRY_MAX && m_data.m22 >= -ENTRY_MAX))
        else $error("m22 out of range");

endmodule

`default_nettype wire

@@ hw/rtl/euzr_sincos.sv @@
// ----------------------------------------------------------------------------
// euzr_sincos
// Pipelined sine and cosine of a Q2.13 angle by a truncated Taylor series.
// ----------------------------------------------------------------------------
`default_nettype none

module euzr_sincos
    import euzr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [ANGLE_W-1:0] angle,
    output sc_t                       result
);

    typedef struct packed {
        logic [U2_W-1:0]        u2;
        logic signed [SC_W-1:0] s_acc;
        logic signed [SC_W-1:0] c_acc;
        logic                   zneg;
        logic                   neg;
    } ctx_t;

    typedef struct packed {
        ctx_t              ctx;
        logic [TERM_W-1:0] s_term;
        logic [TERM_W-1:0] c_term;
    } ser_t;

    // fold into plus or minus pi/2 and take the magnitude
    logic signed [32:0] z_in;
    logic signed [32:0] z_adj;
    logic signed [32:0] z_mag;
    logic               fold;

    always_comb begin
        z_in = {angle[ANGLE_W-1], angle, 16'd0};
        fold = 1'b0;
        priority if (z_in > HALF_PI_Q29) begin
            z_adj = z_in - PI_Q29;
            fold  = 1'b1;
        end else if (z_in < -HALF_PI_Q29) begin
            z_adj = z_in + PI_Q29;
            fold  = 1'b1;
        end else begin
            z_adj = z_in;
        end
        z_mag = z_adj[32] ? -z_adj : z_adj;
    end

    logic [U_W-1:0] u0_reg;
    logic           zneg0_reg;
    logic           neg0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            u0_reg    <= z_mag[U_W-1:0];
            zneg0_reg <= z_adj[32];
            neg0_reg  <= fold;
        end
    end

    // square of the magnitude
    logic [2*U_W-1:0] uu1_reg;
    logic [U_W-1:0]   u1_reg;
    logic             zneg1_reg;
    logic             neg1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            uu1_reg   <= u0_reg * u0_reg;
            u1_reg    <= u0_reg;
            zneg1_reg <= zneg0_reg;
            neg1_reg  <= neg0_reg;
        end
    end

    // round the square to Q29 and seed both series
    logic [2*U_W:0] uu_round;
    ser_t           ser_reg [SERIES_TERMS+1];

    assign uu_round = {1'b0, uu1_reg} + (2*U_W+1)'(1 << 28);

    always_ff @(posedge aclk) begin
        if (en) begin
            ser_reg[0].ctx.u2    <= uu_round[59:29];
            ser_reg[0].ctx.s_acc <= SC_W'(u1_reg);
            ser_reg[0].ctx.c_acc <= SC_W'(Q29_ONE);
            ser_reg[0].ctx.zneg  <= zneg1_reg;
            ser_reg[0].ctx.neg   <= neg1_reg;
            ser_reg[0].s_term    <= TERM_W'(u1_reg);
            ser_reg[0].c_term    <= Q29_ONE;
        end
    end

    // one series term per three stages: product, reciprocal, correction
    for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
        localparam div_t SD = SIN_DIV[k];
        localparam div_t CD = COS_DIV[k];
        localparam logic [TERM_W-1:0] SM = TERM_W'((64'd1 << 31) / 64'(SD));
        localparam logic [TERM_W-1:0] CM = TERM_W'((64'd1 << 31) / 64'(CD));

        ctx_t                a_ctx_reg;
        logic [2*TERM_W-1:0] a_sp_reg;
        logic [2*TERM_W-1:0] a_cp_reg;
        ctx_t                b_ctx_reg;
        logic [TERM_W-1:0]   b_sx_reg;
        logic [TERM_W-1:0]   b_cx_reg;
        logic [2*TERM_W-1:0] b_sy_reg;
        logic [2*TERM_W-1:0] b_cy_reg;
        logic [TERM_W-1:0]   sx;
        logic [TERM_W-1:0]   cx;
        logic [TERM_W-1:0]   sq0;
        logic [TERM_W-1:0]   cq0;
        logic [39:0]         srem;
        logic [39:0]         crem;
        logic [TERM_W-1:0]   sq;
        logic [TERM_W-1:0]   cq;

        // term times squared magnitude
        always_ff @(posedge aclk) begin
            if (en) begin
                a_ctx_reg <= ser_reg[k].ctx;
                a_sp_reg  <= ser_reg[k].s_term * ser_reg[k].ctx.u2;
                a_cp_reg  <= ser_reg[k].c_term * ser_reg[k].ctx.u2;
            end
        end

        // back to Q29, then times the reciprocal of the divisor
        assign sx = a_sp_reg[59:29];
        assign cx = a_cp_reg[59:29];

        always_ff @(posedge aclk) begin
            if (en) begin
                b_ctx_reg <= a_ctx_reg;
                b_sx_reg  <= sx;
                b_cx_reg  <= cx;
                b_sy_reg  <= sx * SM;
                b_cy_reg  <= cx * CM;
            end
        end

        // quotient estimate is low by at most one
        always_comb begin
            sq0  = b_sy_reg[61:31];
            cq0  = b_cy_reg[61:31];
            srem = 40'(b_sx_reg) - 40'(sq0) * 40'(SD);
            crem = 40'(b_cx_reg) - 40'(cq0) * 40'(CD);
            sq   = (srem >= 40'(SD)) ? sq0 + TERM_W'(1) : sq0;
            cq   = (crem >= 40'(CD)) ? cq0 + TERM_W'(1) : cq0;
        end

        // alternate signs, odd terms subtract
        always_ff @(posedge aclk) begin
            if (en) begin
                ser_reg[k+1].ctx.u2   <= b_ctx_reg.u2;
                ser_reg[k+1].ctx.zneg <= b_ctx_reg.zneg;
                ser_reg[k+1].ctx.neg  <= b_ctx_reg.neg;
                ser_reg[k+1].s_term   <= sq;
                ser_reg[k+1].c_term   <= cq;
                if ((k % 2) == 0) begin
                    ser_reg[k+1].ctx.s_acc <= b_ctx_reg.s_acc - SC_W'(sq);
                    ser_reg[k+1].ctx.c_acc <= b_ctx_reg.c_acc - SC_W'(cq);
                end else begin
                    ser_reg[k+1].ctx.s_acc <= b_ctx_reg.s_acc + SC_W'(sq);
                    ser_reg[k+1].ctx.c_acc <= b_ctx_reg.c_acc + SC_W'(cq);
                end
            end
        end
    end

    // restore signs from the magnitude and the pi fold
    logic signed [SC_W-1:0] s_fix;
    logic signed [SC_W-1:0] s_out;
    logic signed [SC_W-1:0] c_out;

    always_comb begin
        s_fix = ser_reg[SERIES_TERMS].ctx.zneg ? -ser_reg[SERIES_TERMS].ctx.s_acc
                                               : ser_reg[SERIES_TERMS].ctx.s_acc;
        s_out = ser_reg[SERIES_TERMS].ctx.neg ? -s_fix : s_fix;
        c_out = ser_reg[SERIES_TERMS].ctx.neg ? -ser_reg[SERIES_TERMS].ctx.c_acc
                                              : ser_reg[SERIES_TERMS].ctx.c_acc;
    end

    sc_t result_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg.sine   <= s_out;
            result_reg.cosine <= c_out;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire
